// ----- rtl/pnd_pkg.sv -----
package pnd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TABLE_BITS = 8;
    localparam int FIFO_BITS  = 4;

    localparam int COORD_W = 32;
    localparam int ENTRY_W = 8;
    localparam int NOISE_W = 16;
    localparam int IN_W    = 2 * COORD_W + 2 * ENTRY_W;

    typedef enum logic {
        OP_EVAL = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

endpackage

// ----- rtl/pnd_perm_ram.sv -----
module pnd_perm_ram #(
    parameter int P_ADDR_BITS = pnd_pkg::TABLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [P_ADDR_BITS-1:0]     i_waddr,
    input  logic [pnd_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [P_ADDR_BITS-1:0]     i_raddr_a,
    input  logic [P_ADDR_BITS-1:0]     i_raddr_b,
    output logic [pnd_pkg::ENTRY_W-1:0] o_rdata_a,
    output logic [pnd_pkg::ENTRY_W-1:0] o_rdata_b
);

    logic [pnd_pkg::ENTRY_W-1:0] r_mem [2**P_ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/pnd_out_fifo.sv -----
module pnd_out_fifo #(
    parameter int P_DEPTH_BITS = pnd_pkg::FIFO_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [pnd_pkg::NOISE_W-1:0] i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output logic [pnd_pkg::NOISE_W-1:0] o_data
);

    logic [pnd_pkg::NOISE_W-1:0] r_mem [2**P_DEPTH_BITS];
    logic [P_DEPTH_BITS-1:0]     r_wp;
    logic [P_DEPTH_BITS-1:0]     r_rp;
    logic [P_DEPTH_BITS:0]       r_cnt;
    logic [P_DEPTH_BITS:0]       n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

// ----- rtl/perlin_noise_2d.sv -----
// Two-dimensional improved Perlin noise. A request with tuser high loads one byte of the
// permutation table; a request with tuser low evaluates noise at a signed Q16.16 point and
// returns one unsigned Q0.16 value. The block takes one request per clock while tready is
// high. A result passes through five pipeline stages, which include the two table lookup
// levels, and is then written into the output queue. Results wait in a 16-entry queue, and
// requests are refused only while 16 evaluations are in flight or queued. All table entries
// must be loaded before evaluating; the table holds no defined contents after reset.
module perlin_noise_2d #(
    parameter int P_FRAC_BITS  = pnd_pkg::FRAC_BITS,
    parameter int P_TABLE_BITS = pnd_pkg::TABLE_BITS,
    parameter int P_FIFO_BITS  = pnd_pkg::FIFO_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // x_coord[31:0], y_coord[63:32], entry_index[71:64], entry_value[79:72]
    input  logic [pnd_pkg::IN_W-1:0]    i_s_axis_tdata,
    // opcode[0]
    input  logic                        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // noise_value[15:0]
    output logic [pnd_pkg::NOISE_W-1:0] o_m_axis_tdata
);

    localparam int F     = P_FRAC_BITS;
    localparam int IW    = P_TABLE_BITS;
    localparam int QW    = F + 6;
    localparam int RW    = QW + pnd_pkg::NOISE_W + 1;
    localparam int DEPTH = 2 ** P_FIFO_BITS;
    localparam int NSTG  = 5;
    localparam logic signed [QW-1:0] ONE = QW'(1) <<< F;

    function automatic logic signed [QW-1:0] f_qmul(input logic signed [QW-1:0] a,
                                                    input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b + ((2*QW)'(1) <<< (F - 1));
        return QW'(p >>> F);
    endfunction

    function automatic logic signed [QW-1:0] f_grad(input logic [2:0] h,
                                                    input logic signed [QW-1:0] x,
                                                    input logic signed [QW-1:0] y);
        logic signed [QW-1:0] g;
        case (h)
            3'd0:    g = x + y;
            3'd1:    g = y - x;
            3'd2:    g = x - y;
            3'd3:    g = -x - y;
            3'd4:    g = x;
            3'd5:    g = -x;
            3'd6:    g = y;
            default: g = -y;
        endcase
        return g;
    endfunction

    logic signed [pnd_pkg::COORD_W-1:0] w_sx, w_sy;
    logic [pnd_pkg::ENTRY_W-1:0]        w_eidx, w_eval;
    logic                               w_acc, w_acc_eval, w_acc_load, w_pop;
    logic signed [QW-1:0]               w_xf, w_yf;
    logic [IW-1:0]                      w_xi, w_yi;

    logic [P_FIFO_BITS:0] r_cnt, n_cnt;
    logic [NSTG-1:0]      r_vld;

    logic signed [QW-1:0] r_s1_xf, r_s1_yf, r_s1_t2x, r_s1_t2y;
    logic [IW-1:0]        r_s1_yi;
    logic signed [QW-1:0] r_s2_xf, r_s2_yf, r_s2_t3x, r_s2_t3y, r_s2_px, r_s2_py;
    logic signed [QW-1:0] r_s3_u, r_s3_v, r_s3_gaa, r_s3_gba, r_s3_gab, r_s3_gbb;
    logic signed [QW-1:0] r_s4_x1, r_s4_x2, r_s4_v;
    logic signed [QW-1:0] r_s5_n;

    logic [pnd_pkg::ENTRY_W-1:0] w_px0, w_px1, w_aa, w_ab, w_ba, w_bb;
    logic [IW-1:0]               w_yi1, w_a_aa, w_a_ab, w_a_ba, w_a_bb;
    logic signed [QW-1:0]        w_xm, w_ym;
    logic signed [QW-1:0]        w_r;
    logic [RW-1:0]               w_q;
    logic [pnd_pkg::NOISE_W-1:0] w_noise;

    assign w_sx   = i_s_axis_tdata[31:0];
    assign w_sy   = i_s_axis_tdata[63:32];
    assign w_eidx = i_s_axis_tdata[71:64];
    assign w_eval = i_s_axis_tdata[79:72];

    assign o_s_axis_tready = (r_cnt < (P_FIFO_BITS + 1)'(DEPTH));
    assign w_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_acc_eval = w_acc && (pnd_pkg::t_opcode'(i_s_axis_tuser) == pnd_pkg::OP_EVAL);
    assign w_acc_load = w_acc && (pnd_pkg::t_opcode'(i_s_axis_tuser) == pnd_pkg::OP_LOAD);
    assign w_pop      = o_m_axis_tvalid && i_m_axis_tready;

    assign w_xf = QW'({1'b0, w_sx[F-1:0]});
    assign w_yf = QW'({1'b0, w_sy[F-1:0]});
    assign w_xi = IW'(w_sx >>> F);
    assign w_yi = IW'(w_sy >>> F);

    always_comb begin
        n_cnt = r_cnt;
        if (w_acc_eval && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_acc_eval && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_vld <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_vld <= {r_vld[NSTG-2:0], w_acc_eval};
        end
    end

    pnd_perm_ram #(.P_ADDR_BITS(IW)) u_ram_l1 (
        .i_clk     (i_clk),
        .i_we      (w_acc_load),
        .i_waddr   (IW'(w_eidx)),
        .i_wdata   (w_eval),
        .i_raddr_a (w_xi),
        .i_raddr_b (w_xi + 1'b1),
        .o_rdata_a (w_px0),
        .o_rdata_b (w_px1)
    );

    assign w_yi1  = r_s1_yi + 1'b1;
    assign w_a_aa = IW'(w_px0) + r_s1_yi;
    assign w_a_ab = IW'(w_px0) + w_yi1;
    assign w_a_ba = IW'(w_px1) + r_s1_yi;
    assign w_a_bb = IW'(w_px1) + w_yi1;

    pnd_perm_ram #(.P_ADDR_BITS(IW)) u_ram_l2a (
        .i_clk     (i_clk),
        .i_we      (w_acc_load),
        .i_waddr   (IW'(w_eidx)),
        .i_wdata   (w_eval),
        .i_raddr_a (w_a_aa),
        .i_raddr_b (w_a_ab),
        .o_rdata_a (w_aa),
        .o_rdata_b (w_ab)
    );

    pnd_perm_ram #(.P_ADDR_BITS(IW)) u_ram_l2b (
        .i_clk     (i_clk),
        .i_we      (w_acc_load),
        .i_waddr   (IW'(w_eidx)),
        .i_wdata   (w_eval),
        .i_raddr_a (w_a_ba),
        .i_raddr_b (w_a_bb),
        .o_rdata_a (w_ba),
        .o_rdata_b (w_bb)
    );

    assign w_xm = r_s2_xf - ONE;
    assign w_ym = r_s2_yf - ONE;

    always_ff @(posedge i_clk) begin
        r_s1_xf  <= w_xf;
        r_s1_yf  <= w_yf;
        r_s1_yi  <= w_yi;
        r_s1_t2x <= f_qmul(w_xf, w_xf);
        r_s1_t2y <= f_qmul(w_yf, w_yf);

        r_s2_xf  <= r_s1_xf;
        r_s2_yf  <= r_s1_yf;
        r_s2_t3x <= f_qmul(r_s1_t2x, r_s1_xf);
        r_s2_t3y <= f_qmul(r_s1_t2y, r_s1_yf);
        r_s2_px  <= (r_s1_t2x <<< 2) + (r_s1_t2x <<< 1) - (r_s1_xf <<< 4) + r_s1_xf
                    + (ONE <<< 3) + (ONE <<< 1);
        r_s2_py  <= (r_s1_t2y <<< 2) + (r_s1_t2y <<< 1) - (r_s1_yf <<< 4) + r_s1_yf
                    + (ONE <<< 3) + (ONE <<< 1);

        r_s3_u   <= f_qmul(r_s2_t3x, r_s2_px);
        r_s3_v   <= f_qmul(r_s2_t3y, r_s2_py);
        r_s3_gaa <= f_grad(w_aa[2:0], r_s2_xf, r_s2_yf);
        r_s3_gba <= f_grad(w_ba[2:0], w_xm, r_s2_yf);
        r_s3_gab <= f_grad(w_ab[2:0], r_s2_xf, w_ym);
        r_s3_gbb <= f_grad(w_bb[2:0], w_xm, w_ym);

        r_s4_x1  <= r_s3_gaa + f_qmul(r_s3_u, r_s3_gba - r_s3_gaa);
        r_s4_x2  <= r_s3_gab + f_qmul(r_s3_u, r_s3_gbb - r_s3_gab);
        r_s4_v   <= r_s3_v;

        r_s5_n   <= r_s4_x1 + f_qmul(r_s4_v, r_s4_x2 - r_s4_x1);
    end

    always_comb begin
        w_r = r_s5_n + ONE;
        if (w_r < 0) begin
            w_r = '0;
        end
        w_q = ((RW'(unsigned'(w_r)) << pnd_pkg::NOISE_W) + (RW'(1) << F)) >> (F + 1);
        if (w_q > RW'(2 ** pnd_pkg::NOISE_W - 1)) begin
            w_noise = '1;
        end else begin
            w_noise = pnd_pkg::NOISE_W'(w_q);
        end
    end

    pnd_out_fifo #(.P_DEPTH_BITS(P_FIFO_BITS)) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_vld[NSTG-1]),
        .i_data  (w_noise),
        .i_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (P_FIFO_BITS + 1)'(DEPTH))
        else $error("in-flight count exceeds queue depth");

    a_eval_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_eval |-> ##5 r_vld[NSTG-1])
        else $error("evaluation did not reach the output queue");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_load |=> !r_vld[0])
        else $error("load request produced a result");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != '0))
        else $error("result delivered with nothing in flight");

endmodule
